// ----- rtl/core/shc_pkg.sv -----
package shc_pkg;

	localparam logic [2:0] LS_ACTIVE   = 3'd0;
	localparam logic [2:0] LS_IDLE     = 3'd1;
	localparam logic [2:0] LS_NEGOT    = 3'd2;
	localparam logic [2:0] LS_SLEEPING = 3'd3;
	localparam logic [2:0] LS_WAKING   = 3'd4;

	localparam logic [2:0] PS_ONLINE   = 3'd0;
	localparam logic [2:0] PS_PENDING  = 3'd1;
	localparam logic [2:0] PS_SLEEPING = 3'd2;
	localparam logic [2:0] PS_UNKNOWN  = 3'd3;
	localparam logic [2:0] PS_OFFLINE  = 3'd4;

	localparam logic [1:0] ROLE_NONE  = 2'd0;
	localparam logic [1:0] ROLE_COORD = 2'd1;
	localparam logic [1:0] ROLE_PART  = 2'd2;

	localparam logic [2:0] PH_NONE        = 3'd0;
	localparam logic [2:0] PH_WAIT_READY  = 3'd1;
	localparam logic [2:0] PH_WAIT_COMMIT = 3'd2;
	localparam logic [2:0] PH_WAIT_ACK    = 3'd3;
	localparam logic [2:0] PH_WAIT_ACK_TX = 3'd4;

	localparam logic [2:0] MT_REQUEST = 3'd0;
	localparam logic [2:0] MT_READY   = 3'd1;
	localparam logic [2:0] MT_COMMIT  = 3'd2;
	localparam logic [2:0] MT_ACK     = 3'd3;
	localparam logic [2:0] MT_CANCEL  = 3'd4;

	localparam logic [3:0] K_TICK     = 4'd0;
	localparam logic [3:0] K_IDLE     = 4'd1;
	localparam logic [3:0] K_REQ      = 4'd2;
	localparam logic [3:0] K_ACT      = 4'd3;
	localparam logic [3:0] K_APP      = 4'd4;
	localparam logic [3:0] K_RX       = 4'd5;
	localparam logic [3:0] K_SENT     = 4'd6;
	localparam logic [3:0] K_FAILED   = 4'd7;
	localparam logic [3:0] K_EXECFAIL = 4'd8;
	localparam logic [3:0] K_SEEN     = 4'd9;
	localparam logic [3:0] K_UNREACH  = 4'd10;
	localparam logic [3:0] K_TAKE     = 4'd11;
	localparam logic [3:0] K_RESTORE  = 4'd12;

	localparam logic [2:0] CFG_LOCAL_ID = 3'd0;
	localparam logic [2:0] CFG_PEER_ID  = 3'd1;
	localparam logic [2:0] CFG_VERSION  = 3'd2;
	localparam logic [2:0] CFG_PHASE    = 3'd3;
	localparam logic [2:0] CFG_HARD     = 3'd4;
	localparam logic [2:0] CFG_COOL     = 3'd5;
	localparam logic [2:0] CFG_WAKE     = 3'd6;

	localparam logic [15:0] SERIAL_HALF = 16'h8000;

	typedef struct packed {
		logic [7:0]  local_id;
		logic [7:0]  peer_id;
		logic [7:0]  version;
		logic [19:0] phase_ms;
		logic [19:0] hard_ms;
		logic [19:0] cool_ms;
		logic [19:0] wake_ms;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  local_mode;
		logic [2:0]  peer_mode;
		logic        txn_open;
		logic [15:0] txn_id;
		logic [1:0]  txn_role;
		logic [2:0]  txn_phase;
		logic [31:0] phase_dl;
		logic [31:0] hard_dl;
		logic        commit_taken;
		logic [15:0] taken_mid;
		logic        rcpt_valid;
		logic [15:0] rcpt_id;
		logic [15:0] rcpt_mid;
		logic        cool_on;
		logic [31:0] cool_dl;
		logic [31:0] wake_dl;
		logic        dec_pending;
		logic [15:0] pend_id;
		logic        pend_role;
		logic        seen_req;
		logic [15:0] newest_id;
	} st_t;

	localparam st_t ST_RESET = '{local_mode: LS_ACTIVE, peer_mode: PS_UNKNOWN,
		txn_role: ROLE_NONE, txn_phase: PH_NONE, default: '0};

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] now_ms;
		logic [7:0]  msg_version;
		logic [7:0]  msg_sender;
		logic [2:0]  msg_type;
		logic        msg_event_none;
		logic [15:0] trans_id;
		logic [15:0] message_id;
		logic        queue_accepts;
		logic        restored_have_request;
	} item_t;

	typedef struct packed {
		logic [2:0]  local_state;
		logic [2:0]  peer_state;
		logic [1:0]  nsend;
		logic [2:0]  type0;
		logic [15:0] id0;
		logic [2:0]  type1;
		logic [15:0] id1;
		logic        accepted;
		logic        decision_valid;
		logic [15:0] decision_id;
		logic        decision_role;
		logic        have_peer_request;
		logic [15:0] newest_peer_request;
	} res_t;

	function automatic logic expired(input logic [31:0] now, input logic [31:0] dl);
		logic [31:0] d;
		d = now - dl;
		return ~d[31];
	endfunction

endpackage

// ----- rtl/core/shc_engine.sv -----
module shc_engine (
	input  shc_pkg::cfg_t  cfg,
	input  shc_pkg::st_t   cur,
	input  shc_pkg::item_t it,
	output shc_pkg::st_t   nxt,
	output shc_pkg::res_t  res
);
	import shc_pkg::*;

	st_t         s;
	logic [1:0]  ns;
	logic [2:0]  t0, t1;
	logic [15:0] i0, i1;
	logic        acc, dv;
	logic [15:0] did;
	logic        drole;
	logic [31:0] now;
	logic [15:0] adv;
	logic [15:0] kid;
	logic        ok;

	always_comb begin
		s = cur;
		ns = 2'd0;
		t0 = '0; t1 = '0; i0 = '0; i1 = '0;
		acc = 1'b0; dv = 1'b0; did = '0; drole = 1'b0;
		now = it.now_ms;
		adv = '0;
		kid = '0;
		ok = 1'b0;

		// Deadline checks are run first for every kind that uses them.
		if (it.kind == K_TICK || it.kind == K_IDLE || it.kind == K_REQ || it.kind == K_ACT
			|| (it.kind == K_APP && cur.txn_open) || it.kind == K_RX
			|| it.kind == K_SENT || it.kind == K_FAILED) begin
			if (s.cool_on && expired(now, s.cool_dl))
				s.cool_on = 1'b0;
			if (s.txn_open && (expired(now, s.hard_dl) || expired(now, s.phase_dl))) begin
				kid = s.txn_id;
				s.txn_open = 1'b0; s.txn_id = '0; s.txn_role = ROLE_NONE;
				s.txn_phase = PH_NONE; s.phase_dl = '0; s.hard_dl = '0;
				s.commit_taken = 1'b0;
				s.rcpt_valid = 1'b0; s.rcpt_id = '0; s.rcpt_mid = '0;
				s.cool_on = 1'b1; s.cool_dl = now + 32'(cfg.cool_ms);
				s.peer_mode = PS_UNKNOWN;
				if (s.local_mode != LS_IDLE) begin
					s.dec_pending = 1'b0;
					s.local_mode = LS_IDLE;
				end
				t0 = MT_CANCEL; i0 = kid; ns = 2'd1;
			end
			if (s.local_mode == LS_WAKING && expired(now, s.wake_dl)) begin
				s.wake_dl = '0;
				s.dec_pending = 1'b0;
				s.local_mode = LS_ACTIVE;
			end
		end

		case (it.kind)
			K_IDLE: begin
				if ((s.local_mode == LS_ACTIVE) || (s.local_mode == LS_IDLE)) begin
					if (s.local_mode != LS_IDLE) s.dec_pending = 1'b0;
					s.local_mode = LS_IDLE;
				end
			end
			K_REQ: begin
				if (s.local_mode == LS_IDLE && !s.txn_open && !s.cool_on) begin
					s.txn_open = 1'b1; s.txn_id = it.trans_id; s.txn_role = ROLE_COORD;
					s.txn_phase = PH_WAIT_READY;
					s.phase_dl = now + 32'(cfg.phase_ms);
					s.hard_dl = now + 32'(cfg.hard_ms);
					s.commit_taken = 1'b0;
					s.rcpt_valid = 1'b0; s.rcpt_id = '0; s.rcpt_mid = '0;
					s.peer_mode = PS_PENDING;
					s.dec_pending = 1'b0;
					s.local_mode = LS_NEGOT;
					ok = 1'b1;
					acc = it.queue_accepts;
				end
			end
			K_ACT, K_APP: begin
				if (it.kind == K_ACT || cur.txn_open) begin
					if (s.txn_open) begin
						kid = s.txn_id;
						s.txn_open = 1'b0; s.txn_id = '0; s.txn_role = ROLE_NONE;
						s.txn_phase = PH_NONE; s.phase_dl = '0; s.hard_dl = '0;
						s.commit_taken = 1'b0;
						s.rcpt_valid = 1'b0; s.rcpt_id = '0; s.rcpt_mid = '0;
						s.cool_on = 1'b1; s.cool_dl = now + 32'(cfg.cool_ms);
						s.peer_mode = PS_ONLINE;
						if (s.local_mode != LS_ACTIVE) s.dec_pending = 1'b0;
						s.local_mode = LS_ACTIVE;
						if (ns == 2'd0) begin t0 = MT_CANCEL; i0 = kid; end
						else begin t1 = MT_CANCEL; i1 = kid; end
						ns = ns + 2'd1;
					end else if (s.local_mode == LS_SLEEPING) begin
						s.rcpt_valid = 1'b0; s.rcpt_id = '0; s.rcpt_mid = '0;
						s.wake_dl = now + 32'(cfg.wake_ms);
						s.dec_pending = 1'b0;
						s.local_mode = LS_WAKING;
					end else if (s.local_mode != LS_WAKING) begin
						if (s.local_mode != LS_ACTIVE) s.dec_pending = 1'b0;
						s.local_mode = LS_ACTIVE;
					end
				end
				if (it.kind == K_APP) s.peer_mode = PS_ONLINE;
			end
			K_RX: begin
				if (it.msg_version == cfg.version && it.msg_sender == cfg.peer_id
					&& it.msg_type <= MT_CANCEL && it.msg_event_none
					&& !(it.msg_type == MT_REQUEST && it.trans_id != it.message_id)) begin
					adv = it.trans_id - s.newest_id;
					if (it.msg_type == MT_REQUEST) begin
						if (s.txn_open && s.txn_role == ROLE_PART && it.trans_id == s.txn_id) begin
							if (!s.commit_taken) begin ok = 1'b1; t0 = MT_READY; end
						end else if (!(s.seen_req && (adv == '0 || adv >= SERIAL_HALF))) begin
							s.seen_req = 1'b1;
							s.newest_id = it.trans_id;
							if (s.txn_open && s.txn_role == ROLE_COORD
								&& s.txn_phase == PH_WAIT_READY) begin
								if (!(cfg.local_id < cfg.peer_id)) begin
									s.txn_id = it.trans_id; s.txn_role = ROLE_PART;
									s.txn_phase = PH_WAIT_COMMIT;
									s.phase_dl = now + 32'(cfg.phase_ms);
									s.commit_taken = 1'b0;
									s.rcpt_valid = 1'b0; s.rcpt_id = '0; s.rcpt_mid = '0;
									s.peer_mode = PS_PENDING;
									if (s.local_mode != LS_NEGOT) s.dec_pending = 1'b0;
									s.local_mode = LS_NEGOT;
									ok = 1'b1; t0 = MT_READY;
								end
							end else if (s.local_mode == LS_IDLE && !s.txn_open && !s.cool_on) begin
								s.txn_open = 1'b1; s.txn_id = it.trans_id; s.txn_role = ROLE_PART;
								s.txn_phase = PH_WAIT_COMMIT;
								s.phase_dl = now + 32'(cfg.phase_ms);
								s.hard_dl = now + 32'(cfg.hard_ms);
								s.commit_taken = 1'b0;
								s.rcpt_valid = 1'b0; s.rcpt_id = '0; s.rcpt_mid = '0;
								s.peer_mode = PS_PENDING;
								s.dec_pending = 1'b0;
								s.local_mode = LS_NEGOT;
								ok = 1'b1; t0 = MT_READY;
							end else if (!s.txn_open) begin
								if (ns == 2'd0) begin t0 = MT_CANCEL; i0 = it.trans_id; end
								else begin t1 = MT_CANCEL; i1 = it.trans_id; end
								ns = ns + 2'd1;
							end
						end
					end else if (!s.txn_open) begin
						if (s.local_mode == LS_SLEEPING && s.rcpt_valid && it.msg_type == MT_COMMIT
							&& it.trans_id == s.rcpt_id && it.message_id == s.rcpt_mid) begin
							if (ns == 2'd0) begin t0 = MT_ACK; i0 = it.trans_id; end
							else begin t1 = MT_ACK; i1 = it.trans_id; end
							ns = ns + 2'd1;
						end
					end else if (it.trans_id == s.txn_id) begin
						if (it.msg_type == MT_CANCEL) begin
							s.txn_open = 1'b0; s.txn_id = '0; s.txn_role = ROLE_NONE;
							s.txn_phase = PH_NONE; s.phase_dl = '0; s.hard_dl = '0;
							s.commit_taken = 1'b0;
							s.rcpt_valid = 1'b0; s.rcpt_id = '0; s.rcpt_mid = '0;
							s.cool_on = 1'b1; s.cool_dl = now + 32'(cfg.cool_ms);
							s.peer_mode = PS_ONLINE;
							if (s.local_mode != LS_IDLE) s.dec_pending = 1'b0;
							s.local_mode = LS_IDLE;
						end else if (it.msg_type == MT_READY && s.txn_role == ROLE_COORD) begin
							if (s.txn_phase == PH_WAIT_READY) begin
								s.txn_phase = PH_WAIT_ACK;
								s.phase_dl = now + 32'(cfg.phase_ms);
								ok = 1'b1; t0 = MT_COMMIT;
							end else if (s.txn_phase == PH_WAIT_ACK) begin
								ok = 1'b1; t0 = MT_COMMIT;
							end
						end else if (it.msg_type == MT_COMMIT && s.txn_role == ROLE_PART
							&& (s.txn_phase == PH_WAIT_COMMIT || s.txn_phase == PH_WAIT_ACK_TX)) begin
							if (s.txn_phase == PH_WAIT_COMMIT) begin
								s.commit_taken = 1'b1;
								s.taken_mid = it.message_id;
								s.txn_phase = PH_WAIT_ACK_TX;
								s.phase_dl = now + 32'(cfg.phase_ms);
							end
							ok = 1'b1; t0 = MT_ACK;
						end else if (it.msg_type == MT_ACK && s.txn_role == ROLE_COORD
							&& s.txn_phase == PH_WAIT_ACK) begin
							s.dec_pending = 1'b1;
							s.pend_id = s.txn_id;
							s.pend_role = 1'b0;
							s.txn_open = 1'b0; s.txn_id = '0; s.txn_role = ROLE_NONE;
							s.txn_phase = PH_NONE; s.phase_dl = '0; s.hard_dl = '0;
							s.commit_taken = 1'b0;
							s.peer_mode = PS_SLEEPING;
							s.local_mode = LS_SLEEPING;
						end
					end
				end
			end
			K_SENT: begin
				if (it.msg_type == MT_ACK && s.txn_open && it.trans_id == s.txn_id
					&& s.txn_role == ROLE_PART && s.txn_phase == PH_WAIT_ACK_TX
					&& s.commit_taken) begin
					s.rcpt_valid = 1'b1; s.rcpt_id = it.trans_id; s.rcpt_mid = s.taken_mid;
					s.dec_pending = 1'b1;
					s.pend_id = s.txn_id;
					s.pend_role = 1'b1;
					s.txn_open = 1'b0; s.txn_id = '0; s.txn_role = ROLE_NONE;
					s.txn_phase = PH_NONE; s.phase_dl = '0; s.hard_dl = '0;
					s.commit_taken = 1'b0;
					s.peer_mode = PS_SLEEPING;
					s.local_mode = LS_SLEEPING;
				end
			end
			K_FAILED: begin
				if ((it.msg_type == MT_ACK && s.local_mode == LS_SLEEPING && s.rcpt_valid
					&& it.trans_id == s.rcpt_id)
					|| (s.txn_open && it.trans_id == s.txn_id
					&& ((s.txn_role == ROLE_COORD
					&& ((it.msg_type == MT_REQUEST && s.txn_phase == PH_WAIT_READY)
					|| (it.msg_type == MT_COMMIT && s.txn_phase == PH_WAIT_ACK)))
					|| (s.txn_role != ROLE_COORD
					&& ((it.msg_type == MT_READY && s.txn_phase == PH_WAIT_COMMIT
					&& !s.commit_taken)
					|| (it.msg_type == MT_ACK && s.txn_phase == PH_WAIT_ACK_TX
					&& s.commit_taken)))))) begin
					if (s.txn_open) begin
						kid = s.txn_id;
						s.txn_open = 1'b0; s.txn_id = '0; s.txn_role = ROLE_NONE;
						s.txn_phase = PH_NONE; s.phase_dl = '0; s.hard_dl = '0;
						s.commit_taken = 1'b0;
						s.rcpt_valid = 1'b0; s.rcpt_id = '0; s.rcpt_mid = '0;
						s.cool_on = 1'b1; s.cool_dl = now + 32'(cfg.cool_ms);
						s.peer_mode = (it.msg_type == MT_REQUEST) ? PS_OFFLINE : PS_UNKNOWN;
						if (s.local_mode != LS_IDLE) s.dec_pending = 1'b0;
						s.local_mode = LS_IDLE;
						if (ns == 2'd0) begin t0 = MT_CANCEL; i0 = kid; end
						else begin t1 = MT_CANCEL; i1 = kid; end
						ns = ns + 2'd1;
					end else begin
						s.peer_mode = PS_UNKNOWN;
					end
				end
			end
			K_EXECFAIL: begin
				if (s.local_mode == LS_SLEEPING && !s.txn_open) begin
					s.rcpt_valid = 1'b0; s.rcpt_id = '0; s.rcpt_mid = '0;
					s.cool_on = 1'b1; s.cool_dl = now + 32'(cfg.cool_ms);
					s.dec_pending = 1'b0;
					s.local_mode = LS_IDLE;
				end
			end
			K_SEEN: begin
				if (s.peer_mode != PS_PENDING && s.peer_mode != PS_SLEEPING)
					s.peer_mode = PS_ONLINE;
			end
			K_UNREACH: begin
				if (s.peer_mode != PS_PENDING && s.peer_mode != PS_SLEEPING)
					s.peer_mode = PS_OFFLINE;
			end
			K_TAKE: begin
				if (s.dec_pending) begin
					dv = 1'b1; did = s.pend_id; drole = s.pend_role;
					s.dec_pending = 1'b0; acc = 1'b1;
				end
			end
			K_RESTORE: begin
				if (s.local_mode == LS_ACTIVE && s.peer_mode == PS_UNKNOWN && !s.txn_open
					&& !s.dec_pending && !s.cool_on) begin
					s.seen_req = it.restored_have_request;
					s.newest_id = it.trans_id;
					acc = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// A control word is sent; a refusal by the queue cancels the transaction.
		// Only one such send occurs per word and never after another send.
		if (ok) begin
			t0 = (it.kind == K_REQ) ? MT_REQUEST : t0;
			i0 = s.txn_id;
			ns = 2'd1;
			if (!it.queue_accepts) begin
				kid = s.txn_id;
				s.txn_open = 1'b0; s.txn_id = '0; s.txn_role = ROLE_NONE;
				s.txn_phase = PH_NONE; s.phase_dl = '0; s.hard_dl = '0;
				s.commit_taken = 1'b0;
				s.rcpt_valid = 1'b0; s.rcpt_id = '0; s.rcpt_mid = '0;
				s.cool_on = 1'b1; s.cool_dl = now + 32'(cfg.cool_ms);
				s.peer_mode = PS_UNKNOWN;
				if (s.local_mode != LS_IDLE) s.dec_pending = 1'b0;
				s.local_mode = LS_IDLE;
				t1 = MT_CANCEL; i1 = kid; ns = 2'd2;
			end
		end

		nxt = s;
		res.local_state = s.local_mode;
		res.peer_state = s.peer_mode;
		res.nsend = ns;
		res.type0 = t0; res.id0 = i0;
		res.type1 = t1; res.id1 = i1;
		res.accepted = acc;
		res.decision_valid = dv;
		res.decision_id = did;
		res.decision_role = drole;
		res.have_peer_request = s.seen_req;
		res.newest_peer_request = s.newest_id;
	end

endmodule

// ----- rtl/core/shc_out.sv -----
module shc_out (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  shc_pkg::res_t  res,
	output logic           busy,
	input  logic           stall,
	output logic           valid,
	output logic [2:0]     local_state,
	output logic [2:0]     peer_state,
	output logic           send_valid,
	output logic [2:0]     send_type,
	output logic [15:0]    send_id,
	output logic           accepted,
	output logic           decision_valid,
	output logic [15:0]    decision_id,
	output logic           decision_role,
	output logic           have_peer_request,
	output logic [15:0]    newest_peer_request,
	output logic           last
);
	import shc_pkg::*;

	res_t r_q;
	logic v_q;
	logic second_q;

	// A word with two sends is shown in two consecutive slots.
	assign busy = v_q && (stall || (r_q.nsend == 2'd2 && !second_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			v_q <= 1'b1;
			second_q <= 1'b0;
		end else if (v_q && !stall) begin
			if (r_q.nsend == 2'd2 && !second_q) begin
				second_q <= 1'b1;
			end else begin
				v_q <= 1'b0;
				second_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) r_q <= res;
	end

	assign valid = v_q;
	assign local_state = r_q.local_state;
	assign peer_state = r_q.peer_state;
	assign send_valid = r_q.nsend != 2'd0;
	assign send_type = second_q ? r_q.type1 : r_q.type0;
	assign send_id = second_q ? r_q.id1 : r_q.id0;
	assign accepted = r_q.accepted;
	assign decision_valid = r_q.decision_valid;
	assign decision_id = r_q.decision_id;
	assign decision_role = r_q.decision_role;
	assign have_peer_request = r_q.have_peer_request;
	assign newest_peer_request = r_q.newest_peer_request;
	assign last = (r_q.nsend != 2'd2) || second_q;

endmodule

// ----- rtl/core/sleep_handshake_controller.sv -----
// Sleep handshake controller between this device and one peer.
// Input channel: in_valid/in_stall carry one event word (kind, time stamp,
// message fields). Output channel: out_valid/out_stall carry result words.
// Each event yields one result word, or two when it causes two control sends;
// last marks the final word of an event.
// The event is evaluated combinationally from the state register, and its
// result is registered on acceptance and shown on the output in the next cycle.
// One event per cycle is taken while the output is free or being drained; an
// event with two sends holds the input while its first word is shown.
// When the receiver stalls, the output word holds and in_stall rises.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready and writes at most one register per handshake.
// Reset puts the block in the active state with the peer unknown, no open
// transaction, and the registers at their default values.
module sleep_handshake_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  kind,
	input  logic [31:0] now_ms,
	input  logic [7:0]  msg_version,
	input  logic [7:0]  msg_sender,
	input  logic [2:0]  msg_type,
	input  logic        msg_event_none,
	input  logic [15:0] trans_id,
	input  logic [15:0] message_id,
	input  logic        queue_accepts,
	input  logic        restored_have_request,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  local_state,
	output logic [2:0]  peer_state,
	output logic        send_valid,
	output logic [2:0]  send_type,
	output logic [15:0] send_id,
	output logic        accepted,
	output logic        decision_valid,
	output logic [15:0] decision_id,
	output logic        decision_role,
	output logic        have_peer_request,
	output logic [15:0] newest_peer_request,
	output logic        last
);
	import shc_pkg::*;

	cfg_t  cfg_q;
	st_t   st_q, st_nxt;
	item_t it;
	res_t  res;
	logic  busy, take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_id <= 8'd0;
			cfg_q.peer_id <= 8'd1;
			cfg_q.version <= 8'd1;
			cfg_q.phase_ms <= 20'd3000;
			cfg_q.hard_ms <= 20'd5000;
			cfg_q.cool_ms <= 20'd3000;
			cfg_q.wake_ms <= 20'd250;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LOCAL_ID: cfg_q.local_id <= cfg_data[7:0];
				CFG_PEER_ID:  cfg_q.peer_id <= cfg_data[7:0];
				CFG_VERSION:  cfg_q.version <= cfg_data[7:0];
				CFG_PHASE:    cfg_q.phase_ms <= cfg_data;
				CFG_HARD:     cfg_q.hard_ms <= cfg_data;
				CFG_COOL:     cfg_q.cool_ms <= cfg_data;
				CFG_WAKE:     cfg_q.wake_ms <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign it.kind = kind;
	assign it.now_ms = now_ms;
	assign it.msg_version = msg_version;
	assign it.msg_sender = msg_sender;
	assign it.msg_type = msg_type;
	assign it.msg_event_none = msg_event_none;
	assign it.trans_id = trans_id;
	assign it.message_id = message_id;
	assign it.queue_accepts = queue_accepts;
	assign it.restored_have_request = restored_have_request;

	shc_engine u_eng (
		.cfg (cfg_q),
		.cur (st_q),
		.it  (it),
		.nxt (st_nxt),
		.res (res)
	);

	assign in_stall = busy;
	assign take = in_valid && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (take) begin
			st_q <= st_nxt;
		end
	end

	shc_out u_out (
		.clk                 (clk),
		.arst_n              (arst_n),
		.load                (take),
		.res                 (res),
		.busy                (busy),
		.stall               (out_stall),
		.valid               (out_valid),
		.local_state         (local_state),
		.peer_state          (peer_state),
		.send_valid          (send_valid),
		.send_type           (send_type),
		.send_id             (send_id),
		.accepted            (accepted),
		.decision_valid      (decision_valid),
		.decision_id         (decision_id),
		.decision_role       (decision_role),
		.have_peer_request   (have_peer_request),
		.newest_peer_request (newest_peer_request),
		.last                (last)
	);

	a_take_loads: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid)
		else $error("accepted event did not produce a result");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall)
		else $error("input taken while output is stalled");

	a_send_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !send_valid) |-> last)
		else $error("non-send result is not last");

endmodule
